FILE: hdl/tfc_pkg.sv
// shared constants and types for the test frame checker
package tfc_pkg;

  localparam logic [7:0]  SOF_BYTE      = 8'hAA;
  localparam logic [7:0]  MARKER_BYTE   = 8'hBB;
  localparam logic [17:0] MIN_FRAME     = 18'd6;
  localparam logic [17:0] HDR_OVERHEAD  = 18'd4;
  localparam int          POS_BITS      = 17;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // byte positions of the header fields
  localparam logic [POS_BITS-1:0] POS_SOF    = 17'd0;
  localparam logic [POS_BITS-1:0] POS_LEN_HI = 17'd1;
  localparam logic [POS_BITS-1:0] POS_LEN_LO = 17'd2;
  localparam logic [POS_BITS-1:0] POS_MARKER = 17'd3;
  localparam logic [7:0]          PAYLOAD_OFFSET = 8'd4;

  localparam logic [15:0] EXP_LEN_RESET = 16'd56;

  // register index decoded from paddr[2]
  localparam logic REG_EXP_LEN = 1'b0;

  typedef struct packed {
    logic [31:0] frames_failed;
    logic [31:0] frames_seen;
    logic        frame_good;
  } result_t;

endpackage

FILE: hdl/tfc_core.sv
// frame state tracking, per-byte checks and saturating frame counters
module tfc_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             byte_accept,
  input  logic [7:0]       rx_byte,
  input  logic             frame_end,
  input  logic [15:0]      exp_len,
  output logic             res_valid,
  output tfc_pkg::result_t res
);
  import tfc_pkg::*;

  localparam int WIDE_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  logic [POS_BITS-1:0]   pos_r, pos_nxt;
  logic [7:0]            sum_r, sum_nxt;
  logic                  fault_r, fault_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [COUNT_BITS-1:0] failed_r, failed_nxt;
  logic                  byte_ok;
  logic                  good;
  logic [17:0]           frame_size;
  logic [17:0]           exp_size;
  logic [WIDE_BITS-1:0]  total_wide, failed_wide;

  always_comb begin
    case (pos_r)
      POS_SOF:    byte_ok = (rx_byte == SOF_BYTE);
      POS_LEN_HI: byte_ok = (rx_byte == exp_len[15:8]);
      POS_LEN_LO: byte_ok = (rx_byte == exp_len[7:0]);
      POS_MARKER: byte_ok = (rx_byte == MARKER_BYTE);
      default:    byte_ok = (rx_byte == (pos_r[7:0] - PAYLOAD_OFFSET));
    endcase
  end

  assign frame_size = {1'b0, pos_r} + 18'd1;
  assign exp_size   = {2'b00, exp_len} + HDR_OVERHEAD;
  assign good = !fault_r && (frame_size >= MIN_FRAME) && (frame_size == exp_size)
                && (rx_byte == sum_r);

  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    fault_nxt  = fault_r;
    total_nxt  = total_r;
    failed_nxt = failed_r;
    if (byte_accept) begin
      if (!frame_end) begin
        if (!byte_ok) begin
          fault_nxt = 1'b1;
        end
        // checksum runs from the marker onward
        if (pos_r >= POS_MARKER) begin
          sum_nxt = sum_r + rx_byte;
        end
        if (pos_r != POS_MAX) begin
          pos_nxt = pos_r + 17'd1;
        end
      end else begin
        if (total_r != '1) begin
          total_nxt = total_r + 1'b1;
        end
        if (!good && failed_r != '1) begin
          failed_nxt = failed_r + 1'b1;
        end
        pos_nxt   = '0;
        sum_nxt   = '0;
        fault_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      fault_r  <= 1'b0;
      total_r  <= '0;
      failed_r <= '0;
    end else begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      fault_r  <= fault_nxt;
      total_r  <= total_nxt;
      failed_r <= failed_nxt;
    end
  end

  assign total_wide  = WIDE_BITS'(total_nxt);
  assign failed_wide = WIDE_BITS'(failed_nxt);

  assign res_valid         = byte_accept && frame_end;
  assign res.frame_good    = good;
  assign res.frames_seen   = total_wide[31:0];
  assign res.frames_failed = failed_wide[31:0];

endmodule

FILE: hdl/test_frame_checker_top.sv
// link test frame checker: stream in, verdict stream out, apb length register
// the verdict of the last byte's transaction is registered onto out_, through the skid entry while out_ is stalled
// throughput: one byte per cycle while the skid entry is empty, set by the single compare-and-add stage in tfc_core
// a two-entry output buffer keeps in_tready high while one verdict waits
// reset: synchronous active-low rst_n clears frame state, counters and the
// output buffer, and sets the expected length to 56
module test_frame_checker_top #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [0] frame_good, [32:1] frames_seen,
                                  // [64:33] frames_failed, [71:65] zero
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tfc_pkg::*;

  logic [15:0] exp_len_r;
  logic        cfg_wr;
  logic        byte_accept;
  logic        res_valid;
  result_t     res;
  result_t     main_r;
  result_t     skid_r;
  logic        main_valid_r;
  logic        skid_valid_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_EXP_LEN) ? {16'd0, exp_len_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= EXP_LEN_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_EXP_LEN) begin
      exp_len_r <= cfg_pwdata[15:0];
    end
  end

  assign in_tready   = !skid_valid_r;
  assign byte_accept = in_tvalid && in_tready;

  tfc_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_accept(byte_accept),
    .rx_byte    (in_tdata),
    .frame_end  (in_tlast),
    .exp_len    (exp_len_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || out_tready) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || out_tready) begin
      main_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = main_valid_r;
  assign out_tdata  = {7'd0, main_r};

endmodule

FILE: hdl/tfc_checker.sv
// port-level checks for the test frame checker, bound to the top level
module tfc_checker #(
  parameter int COUNT_BITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // a held verdict does not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("verdict changed while stalled");

  // input back-pressure only when the output buffer is full
  a_ready_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // no failed frames beyond frames seen
  a_fail_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (COUNT_BITS > 32) || (out_tdata[64:33] <= out_tdata[32:1]))
    else $error("failed count exceeds total");

  // a passing frame leaves the failed count below the total unless the total has saturated
  a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> (COUNT_BITS != 32) || (out_tdata[32:1] != out_tdata[64:33])
      || (out_tdata[32:1] == 32'hFFFF_FFFF))
    else $error("good frame with failed count equal to total");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind test_frame_checker_top tfc_checker #(.COUNT_BITS(COUNT_BITS)) u_tfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
